@@ rtl/core/sorted_priority_queue_macros.svh @@
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

@@ rtl/core/spq_pkg.sv @@
// Types and constants of the sorted priority queue.
package spq_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic      push;
      logic      pop;
      value_type value;
   } op_type;

endpackage

@@ rtl/core/spq_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface spq_req_if;
   import spq_pkg::*;

   logic      valid;
   logic      ready;
   cmd_type   cmd;
   value_type value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic      valid;
   logic      ready;
   logic      ok;
   value_type head_value;
   logic      head_valid;
   count_type count;

   modport source (output valid, output ok, output head_value, output head_valid,
                   output count, input ready);
   modport sink   (input valid, input ok, input head_value, input head_valid,
                   input count, output ready);
endinterface

@@ rtl/core/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: cell chain, count and response register.
//
//   channel | dir | beat
//   --------+-----+----------------------------------------------------
//   req     | in  | cmd (push/pop), value
//   rsp     | out | ok, head_value, head_valid, count (after the op)
//
// One beat per cycle: a request is taken in the cycle the response slot is
// empty or being drained, and its response shows in the next cycle.
// Every cell compares against the broadcast value in parallel, so the whole
// chain shifts at once; the response register is the only limit on rate.
// A stalled response holds req_chan.ready low; the store stays unchanged.
// Synchronous reset empties the queue (count only); cell contents are not
// cleared, since slots at or above the count are never read.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          ok_ff;
   logic          ok_in;

   logic          fire;
   logic          full;
   logic          empty;
   op_type        op;

   value_type     cell_value [DEPTH];
   logic          cell_gt    [DEPTH];

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // Accept only when the response slot is free or being emptied now.
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign fire           = req_chan.valid && req_chan.ready;

   assign op.push  = fire && (req_chan.cmd == CMD_PUSH) && !full;
   assign op.pop   = fire && (req_chan.cmd == CMD_POP) && !empty;
   assign op.value = req_chan.value;

   // Chain of cells; cell 0 holds the head. Occupancy follows the count.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               occupied;
      logic               at_tail;
      value_type          left_value;
      logic               left_gt;
      value_type          right_value;

      assign occupied = (CW'(i) < count_ff);
      assign at_tail  = (CW'(i) == count_ff);

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .occupied    (occupied),
         .at_tail     (at_tail),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.push) begin
         count_in = count_ff + CW'(1);
      end else if (op.pop) begin
         count_in = count_ff - CW'(1);
      end

      ok_in = fire ? (op.push || op.pop) : ok_ff;

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff <= ok_in;
   end

   // Store is frozen while a response waits, so fields read the state directly.
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = ok_ff;
   assign rsp_chan.head_valid = !empty;
   assign rsp_chan.head_value = empty ? '0 : cell_value[0];
   assign rsp_chan.count      = COUNT_W'(count_ff);

endmodule

@@ rtl/core/spq_cell.sv @@
// One slot of the sorted chain: holds a value and shifts with its neighbors.
module spq_cell (
   input  logic               clock,
   input  spq_pkg::op_type    op,
   input  logic               occupied,
   input  logic               at_tail,
   input  spq_pkg::value_type left_value,
   input  logic               left_gt,
   input  spq_pkg::value_type right_value,
   output spq_pkg::value_type value,
   output logic               gt
);
   import spq_pkg::*;

   value_type value_ff;
   value_type value_in;

   // Stored entry is strictly larger than the pushed value.
   assign gt    = occupied && (value_ff > op.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (op.push) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || at_tail) begin
            value_in = op.value;
         end
      end else if (op.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ rtl/core/spq_checker.sv @@
// Port-level checks of the sorted priority queue and their bind.
`include "sorted_priority_queue_macros.svh"

module spq_checker #(
   parameter int DEPTH = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_ok,
   input spq_pkg::value_type rsp_head_value,
   input logic               rsp_head_valid,
   input spq_pkg::count_type rsp_count
);
   import spq_pkg::*;

   logic                       rsp_stall;
   logic [VALUE_W+COUNT_W+1:0] rsp_fields;
   logic                       rsp_zeroed;
   logic                       rsp_at_bound;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_fields   = {rsp_ok, rsp_head_value, rsp_head_valid, rsp_count};
   assign rsp_zeroed   = (rsp_head_value == '0) && (rsp_count == '0);
   assign rsp_at_bound = (rsp_count == '0) || (rsp_count == COUNT_W'(DEPTH));

   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))
   `SPQ_ASSERT_NEXT(a_req_gets_rsp, clock, reset, req_valid && req_ready, rsp_valid)
   `SPQ_ASSERT_NOW(a_empty_head, clock, reset, rsp_valid && !rsp_head_valid, rsp_zeroed)
   `SPQ_ASSERT_NOW(a_refuse_bound, clock, reset, rsp_valid && !rsp_ok, rsp_at_bound)

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_ok         (rsp_chan.ok),
   .rsp_head_value (rsp_chan.head_value),
   .rsp_head_valid (rsp_chan.head_valid),
   .rsp_count      (rsp_chan.count)
);

@@ tb/sorted_priority_queue_test.sv @@
// Self-checking testbench for the sorted priority queue: directed corners, then random traffic.
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
   localparam int HOLD_CYCLES = 120;      // long receiver hold-off
   localparam int SETTLE      = 10;       // quiet cycles before the verdict

   // One response beat as the block should report it.
   typedef struct {
      logic      ok;
      value_type head_value;
      logic      head_valid;
      count_type count;
   } status_beat_type;

   // Shadow copy of the sorted store plus the list of responses still owed.
   class queue_shadow_type;
      value_type       sorted_copy[$];
      status_beat_type pending_status[$];
      int              errors;

      // Apply one accepted request beat and queue the response it must produce.
      function void note_request(cmd_type op, value_type val);
         status_beat_type s;
         int              pos;
         s.ok = 1'b0;
         if (op == CMD_PUSH) begin
            if (sorted_copy.size() < DEPTH) begin
               // Equal values stay in arrival order: insert after the last equal one.
               pos = 0;
               while (pos < sorted_copy.size() && sorted_copy[pos] <= val)
                  pos++;
               sorted_copy.insert(pos, val);
               s.ok = 1'b1;
            end
         end else if (sorted_copy.size() > 0) begin
            void'(sorted_copy.pop_front());
            s.ok = 1'b1;
         end
         s.head_valid = (sorted_copy.size() > 0);
         s.head_value = s.head_valid ? sorted_copy[0] : '0;
         s.count      = count_type'(sorted_copy.size());
         pending_status.push_back(s);
      endfunction

      // Compare one accepted response beat with the oldest owed response.
      function void check_response(logic ok, value_type head_value, logic head_valid,
                                   count_type count);
         status_beat_type e;
         if (pending_status.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         e = pending_status.pop_front();
         if (ok !== e.ok) begin
            $error("ok: expected %0d, got %0d", e.ok, ok);
            errors++;
         end
         if (head_value !== e.head_value) begin
            $error("head_value: expected %0d, got %0d", e.head_value, head_value);
            errors++;
         end
         if (head_valid !== e.head_valid) begin
            $error("head_valid: expected %0d, got %0d", e.head_valid, head_valid);
            errors++;
         end
         if (count !== e.count) begin
            $error("count: expected %0d, got %0d", e.count, count);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_status.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   queue_shadow_type shadow = new();

   int send_idle_pct;    // chance in percent that the sender skips a cycle
   int recv_idle_pct;    // chance in percent that the receiver drops ready
   int holds_asked;      // bumped by the stimulus to request a long hold-off
   int holds_seen;       // receiver's own copy of holds_asked
   int hold_left;        // hold-off cycles still to go
   int cycle_count;

   always #4 clock = ~clock;

   // Receiver: random ready, plus a long hold-off on request. During the
   // hold-off the response slot stays full, so the block must stall req.
   always @(posedge clock) begin
      if (holds_seen != holds_asked) begin
         holds_seen <= holds_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: values read right after the edge are the ones the edge saw,
   // since everything else moves by nonblocking update.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            shadow.note_request(req_bus.cmd, req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready)
            shadow.check_response(rsp_bus.ok, rsp_bus.head_value, rsp_bus.head_valid,
                                  rsp_bus.count);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sorted_priority_queue_test failed");
         $finish;
      end
   end

   // Offer one request beat and hold it until the block takes it. Random idle
   // cycles go in front; valid stays high from one beat to the next otherwise.
   task automatic offer_request(input cmd_type op, input value_type val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= op;
      req_bus.value <= val;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   // Stop offering and wait until every owed response has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (shadow.outstanding() != 0)
         @(posedge clock);
   endtask

   // Random traffic in bursts that lean toward push or pop, so the queue
   // swings between empty and full. Values mix tiny (lots of ties), extremes
   // and full-range random words.
   task automatic run_traffic(input int items);
      int        left;
      int        burst;
      int        push_pct;
      cmd_type   op;
      value_type val;
      left = items;
      while (left > 0) begin
         burst = $urandom_range(40, 8);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 25;
            default: push_pct = 55;
         endcase
         for (int k = 0; k < burst && left > 0; k++) begin
            op = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            case ($urandom_range(3))
               0: val = value_type'($urandom_range(4) - 2);
               1: val = $urandom_range(1) ? value_type'(32'h7fff_ffff - $urandom_range(1))
                                          : value_type'(32'h8000_0000 + $urandom_range(1));
               default: val = value_type'($urandom);
            endcase
            offer_request(op, val);
            left--;
         end
      end
   endtask

   // Directed fill: extremes, alternating bit patterns, ties and a spread of
   // small values, ordered so the second entry takes the head and keeps it.
   value_type fill_values[DEPTH] = '{
      32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5, 32'sd5,
      32'sh5555_5555, 32'shaaaa_aaaa, -32'sd7, 32'sd100, -32'sd100, 32'sd2, 32'sd3, 32'sd4
   };

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_PUSH;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      holds_asked   = 0;
      holds_seen    = 0;
      hold_left     = 0;
      cycle_count   = 0;
      send_idle_pct = 30;
      recv_idle_pct = 68;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: pop on empty is refused, fill to the brim, push on full is refused,
      // then pop twice, re-insert the minimum at the front and pop it again.
      offer_request(CMD_POP, 32'sh1234_5678);
      foreach (fill_values[i])
         offer_request(CMD_PUSH, fill_values[i]);
      offer_request(CMD_PUSH, 32'sd9);
      offer_request(CMD_POP, '0);
      offer_request(CMD_POP, '0);
      offer_request(CMD_PUSH, 32'sh8000_0000);
      offer_request(CMD_POP, '1);
      drain_responses();

      // Sender idles lightly, receiver heavily.
      run_traffic(200);
      drain_responses();

      // Roles swapped.
      send_idle_pct = 68;
      recv_idle_pct = 30;
      run_traffic(200);
      drain_responses();

      // Full rate; the receiver holds off for a long stretch while requests
      // keep coming, so the block backs up and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked <= holds_asked + 1;
      run_traffic(200);
      drain_responses();

      repeat (SETTLE) @(posedge clock);
      if (shadow.errors == 0 && shadow.outstanding() == 0)
         $display("sorted_priority_queue_test passed");
      else
         $display("sorted_priority_queue_test failed");
      $finish;
   end

endmodule
